// ----- hw/rtl/fph_pkg.sv -----
// Shared types and codes for the fit-policy hole allocator.
// No dependencies; imported by every module of the block.
package fph_pkg;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_BAD_SIZE = 3'd1,
      ST_NO_FIT   = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      PL_FIRST = 2'd0,
      PL_BEST  = 2'd1,
      PL_WORST = 2'd2,
      PL_NONE  = 2'd3
   } placement_type;

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_SPARE = 2'd3;

   localparam logic CSR_CAPACITY  = 1'b0;
   localparam logic CSR_PLACEMENT = 1'b1;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  chunk_name;
      logic [15:0] request_size;
   } req_type;

   typedef struct packed {
      logic [15:0] start_addr;
      logic [2:0]  status;
      logic [15:0] used_total;
   } rsp_type;

endpackage

// ----- hw/rtl/fit_policy_hole_allocator.sv -----
// Top level of the fit-policy hole allocator: hole and chunk tables and the
// sequencer that walks them. Depends on fph_pkg.
//
// One word is processed at a time. An allocate scans the hole table one entry
// per cycle with a single compare unit, then shifts the tables one entry per
// cycle; a free scans the chunk table and then the hole table the same way.
// A free steps through the chunk scan, the hole scan, the merge, chunk removal,
// then hole removal or insertion, and the result; an allocate through the hole
// scan, the pick, hole removal on an exact fit, chunk insertion and the result.
// A clear answers straight from the idle state.
// The result word waits in an output register; req_ready is low while an
// operation is in flight or its result has not been taken. Capacity writes
// take effect at the next clear.
module fit_policy_hole_allocator #(
   parameter int HOLE_ENTRIES  = 16,
   parameter int CHUNK_ENTRIES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fph_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fph_pkg::rsp_type  rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [15:0]       csr_wdata
);
   import fph_pkg::*;

   localparam int HW = $clog2(HOLE_ENTRIES);
   localparam int CW = (CHUNK_ENTRIES > 1) ? $clog2(CHUNK_ENTRIES) : 1;
   localparam int HC = $clog2(HOLE_ENTRIES + 1);
   localparam int CC = $clog2(CHUNK_ENTRIES + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_HSCAN, S_ALLOC, S_HDROP, S_CSCAN, S_FSCAN, S_FDEC,
      S_CDROP, S_HPUSH, S_CPUSH, S_DONE
   } state_type;

   // Tables, packed from entry 0; counts replace per-entry valid bits.
   logic [15:0] hs_ff [HOLE_ENTRIES];
   logic [15:0] hl_ff [HOLE_ENTRIES];
   logic [7:0]  cn_ff [CHUNK_ENTRIES];
   logic [15:0] cs_ff [CHUNK_ENTRIES];
   logic [15:0] cl_ff [CHUNK_ENTRIES];
   logic [HC-1:0] nh_ff;
   logic [CC-1:0] nc_ff;

   logic [15:0] cap_ff;
   logic [1:0]  plc_ff;
   logic [15:0] used_ff;
   state_type   st_ff;
   req_type     req_ff;
   rsp_type     rsp_ff;
   logic        rv_ff;
   logic [HC-1:0] hi_ff;       // hole scan / shift index
   logic [CC-1:0] ci_ff;       // chunk scan / shift index
   logic        pk_ok_ff;
   logic [HW-1:0] pk_ff;
   logic [15:0] pl_ff;         // length of the picked hole
   logic [HC-1:0] rear_ff, front_ff;
   logic        rear_ok_ff, front_ok_ff;
   logic [15:0] fs_ff, fl_ff;  // chunk being freed or allocated

   assign req_ready = (st_ff == S_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   // Shared scan unit: current hole entry.
   logic [HW-1:0] hidx;
   logic [15:0]   hs_cur, hl_cur;
   logic [16:0]   hend;
   logic [16:0]   cend;
   assign hidx   = hi_ff[HW-1:0];
   assign hs_cur = hs_ff[hidx];
   assign hl_cur = hl_ff[hidx];
   assign hend   = {1'b0, hs_cur} + {1'b0, hl_cur};
   assign cend   = {1'b0, fs_ff} + {1'b0, fl_ff};

   logic better;
   always_comb begin
      case (plc_ff)
         PL_FIRST: better = !pk_ok_ff;
         PL_BEST:  better = !pk_ok_ff || (hl_cur < pl_ff);
         PL_WORST: better = !pk_ok_ff || (hl_cur > pl_ff);
         default:  better = 1'b0;
      endcase
   end

   function automatic rsp_type mk(logic [15:0] a, status_type s, logic [15:0] u);
      rsp_type r;
      r.start_addr = a;
      r.status = s;
      r.used_total = u;
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         rv_ff <= 1'b0;
         cap_ff <= 16'd100;
         plc_ff <= 2'd0;
         used_ff <= '0;
         nc_ff <= '0;
         nh_ff <= HC'(1);
         hs_ff[0] <= '0;
         hl_ff[0] <= 16'd100;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_CAPACITY) cap_ff <= csr_wdata;
            else plc_ff <= csr_wdata[1:0];
         end
         if (rv_ff && rsp_ready) rv_ff <= 1'b0;
         unique case (st_ff)
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  req_ff <= req_data;
                  hi_ff <= '0;
                  ci_ff <= '0;
                  pk_ok_ff <= 1'b0;
                  rear_ok_ff <= 1'b0;
                  front_ok_ff <= 1'b0;
                  case (req_data.op)
                     OP_ALLOC: begin
                        if (req_data.request_size == '0) begin
                           rsp_ff <= mk('0, ST_BAD_SIZE, used_ff);
                           rv_ff <= 1'b1;
                        end else st_ff <= S_HSCAN;
                     end
                     OP_FREE: st_ff <= S_CSCAN;
                     OP_CLEAR: begin
                        used_ff <= '0;
                        nc_ff <= '0;
                        hs_ff[0] <= '0;
                        hl_ff[0] <= cap_ff;
                        nh_ff <= (cap_ff != '0) ? HC'(1) : '0;
                        rsp_ff <= mk('0, ST_OK, '0);
                        rv_ff <= 1'b1;
                     end
                     default: begin
                        rsp_ff <= mk('0, ST_OK, used_ff);
                        rv_ff <= 1'b1;
                     end
                  endcase
               end
            end
            S_HSCAN: begin
               if (hi_ff == nh_ff) begin
                  st_ff <= S_ALLOC;
               end else begin
                  if (hl_cur >= req_ff.request_size && better) begin
                     pk_ok_ff <= 1'b1;
                     pk_ff <= hidx;
                     pl_ff <= hl_cur;
                  end
                  hi_ff <= hi_ff + HC'(1);
               end
            end
            S_ALLOC: begin
               if (!pk_ok_ff) begin
                  rsp_ff <= mk('0, ST_NO_FIT, used_ff);
                  rv_ff <= 1'b1;
                  st_ff <= S_IDLE;
               end else if (nc_ff == CC'(CHUNK_ENTRIES)) begin
                  rsp_ff <= mk('0, ST_FULL, used_ff);
                  rv_ff <= 1'b1;
                  st_ff <= S_IDLE;
               end else begin
                  fs_ff <= hs_ff[pk_ff];
                  fl_ff <= req_ff.request_size;
                  hs_ff[pk_ff] <= hs_ff[pk_ff] + req_ff.request_size;
                  hl_ff[pk_ff] <= pl_ff - req_ff.request_size;
                  used_ff <= used_ff + req_ff.request_size;
                  ci_ff <= nc_ff;
                  hi_ff <= HC'(pk_ff);
                  st_ff <= (pl_ff == req_ff.request_size) ? S_HDROP : S_CPUSH;
               end
            end
            S_HDROP: begin
               // Close the gap at hi_ff, one entry per cycle.
               if (hi_ff + HC'(1) >= nh_ff) begin
                  nh_ff <= nh_ff - HC'(1);
                  st_ff <= (req_ff.op == OP_ALLOC) ? S_CPUSH : S_DONE;
               end else begin
                  hs_ff[hidx] <= hs_ff[HW'(hi_ff + HC'(1))];
                  hl_ff[hidx] <= hl_ff[HW'(hi_ff + HC'(1))];
                  hi_ff <= hi_ff + HC'(1);
               end
            end
            S_CPUSH: begin
               if (ci_ff == '0) begin
                  cn_ff[0] <= req_ff.chunk_name;
                  cs_ff[0] <= fs_ff;
                  cl_ff[0] <= fl_ff;
                  nc_ff <= nc_ff + CC'(1);
                  rsp_ff <= mk(fs_ff, ST_OK, used_ff);
                  rv_ff <= 1'b1;
                  st_ff <= S_IDLE;
               end else begin
                  cn_ff[CW'(ci_ff)] <= cn_ff[CW'(ci_ff - CC'(1))];
                  cs_ff[CW'(ci_ff)] <= cs_ff[CW'(ci_ff - CC'(1))];
                  cl_ff[CW'(ci_ff)] <= cl_ff[CW'(ci_ff - CC'(1))];
                  ci_ff <= ci_ff - CC'(1);
               end
            end
            S_CSCAN: begin
               if (ci_ff == nc_ff) begin
                  rsp_ff <= mk('0, ST_NOT_FOUND, used_ff);
                  rv_ff <= 1'b1;
                  st_ff <= S_IDLE;
               end else if (cn_ff[CW'(ci_ff)] == req_ff.chunk_name) begin
                  fs_ff <= cs_ff[CW'(ci_ff)];
                  fl_ff <= cl_ff[CW'(ci_ff)];
                  st_ff <= S_FSCAN;
               end else ci_ff <= ci_ff + CC'(1);
            end
            S_FSCAN: begin
               if (hi_ff == nh_ff) begin
                  st_ff <= S_FDEC;
               end else begin
                  if (fs_ff < hs_cur && cend == {1'b0, hs_cur}) begin
                     rear_ok_ff <= 1'b1;
                     rear_ff <= hi_ff;
                  end
                  if (fs_ff > hs_cur && hend == {1'b0, fs_ff}) begin
                     front_ok_ff <= 1'b1;
                     front_ff <= hi_ff;
                  end
                  hi_ff <= hi_ff + HC'(1);
               end
            end
            S_FDEC: begin
               if (!rear_ok_ff && !front_ok_ff && nh_ff == HC'(HOLE_ENTRIES)) begin
                  rsp_ff <= mk('0, ST_FULL, used_ff);
                  rv_ff <= 1'b1;
                  st_ff <= S_IDLE;
               end else begin
                  used_ff <= used_ff - fl_ff;
                  if (rear_ok_ff && front_ok_ff) begin
                     hl_ff[HW'(front_ff)] <= hl_ff[HW'(front_ff)] + fl_ff
                                            + hl_ff[HW'(rear_ff)];
                  end else if (rear_ok_ff) begin
                     hs_ff[HW'(rear_ff)] <= fs_ff;
                     hl_ff[HW'(rear_ff)] <= hl_ff[HW'(rear_ff)] + fl_ff;
                  end else if (front_ok_ff) begin
                     hl_ff[HW'(front_ff)] <= hl_ff[HW'(front_ff)] + fl_ff;
                  end
                  st_ff <= S_CDROP;
               end
            end
            S_CDROP: begin
               if (ci_ff + CC'(1) >= nc_ff) begin
                  nc_ff <= nc_ff - CC'(1);
                  if (rear_ok_ff && front_ok_ff) begin
                     hi_ff <= rear_ff;
                     st_ff <= S_HDROP;
                  end else if (rear_ok_ff || front_ok_ff) begin
                     st_ff <= S_DONE;
                  end else begin
                     hi_ff <= nh_ff;
                     st_ff <= S_HPUSH;
                  end
               end else begin
                  cn_ff[CW'(ci_ff)] <= cn_ff[CW'(ci_ff + CC'(1))];
                  cs_ff[CW'(ci_ff)] <= cs_ff[CW'(ci_ff + CC'(1))];
                  cl_ff[CW'(ci_ff)] <= cl_ff[CW'(ci_ff + CC'(1))];
                  ci_ff <= ci_ff + CC'(1);
               end
            end
            S_HPUSH: begin
               if (hi_ff == '0) begin
                  hs_ff[0] <= fs_ff;
                  hl_ff[0] <= fl_ff;
                  nh_ff <= nh_ff + HC'(1);
                  st_ff <= S_DONE;
               end else begin
                  hs_ff[hidx] <= hs_ff[HW'(hi_ff - HC'(1))];
                  hl_ff[hidx] <= hl_ff[HW'(hi_ff - HC'(1))];
                  hi_ff <= hi_ff - HC'(1);
               end
            end
            S_DONE: begin
               rsp_ff <= mk('0, ST_OK, used_ff);
               rv_ff <= 1'b1;
               st_ff <= S_IDLE;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ----- tb/fit_policy_hole_allocator_test.sv -----
// Self-checking testbench for the fit-policy hole allocator.
// Depends on fph_pkg and fit_policy_hole_allocator; needs no other file.
module fit_policy_hole_allocator_test;
   timeunit 1ns;
   timeprecision 1ps;
   import fph_pkg::*;

   localparam int HOLES = 16;
   localparam int CHUNKS = 16;
   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic csr_index = 1'b0;
   logic [15:0] csr_wdata = '0;

   fit_policy_hole_allocator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The predictor's own copy of the allocator state. Unused table entries are
   // kept at zero so that shifts behave exactly like the packed hardware lists.
   logic [15:0] cfg_capacity;
   placement_type cfg_placement;
   logic [15:0] hole_base [HOLES];
   logic [15:0] hole_size [HOLES];
   int hole_count;
   logic [7:0] chunk_tag [CHUNKS];
   logic [15:0] chunk_base [CHUNKS];
   logic [15:0] chunk_size [CHUNKS];
   int chunk_count;
   logic [15:0] units_in_use;

   rsp_type expected_words[$];
   int mismatches = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int quiet_cycles = 0;

   function automatic void wipe_tables();
      for (int k = 0; k < HOLES; k++) begin
         hole_base[k] = '0;
         hole_size[k] = '0;
      end
      for (int k = 0; k < CHUNKS; k++) begin
         chunk_tag[k] = '0;
         chunk_base[k] = '0;
         chunk_size[k] = '0;
      end
      hole_count = 0;
      chunk_count = 0;
      units_in_use = '0;
      if (cfg_capacity != 0) begin
         hole_size[0] = cfg_capacity;
         hole_count = 1;
      end
   endfunction

   function automatic void remove_hole(int idx);
      for (int k = idx; k + 1 < hole_count; k++) begin
         hole_base[k] = hole_base[k + 1];
         hole_size[k] = hole_size[k + 1];
      end
      hole_count--;
      hole_base[hole_count] = '0;
      hole_size[hole_count] = '0;
   endfunction

   // Computes the result word for one request and advances the predicted state.
   function automatic rsp_type allocator_result(req_type rq);
      rsp_type r;
      int pick;
      int found;
      int upper;
      int lower;
      logic [16:0] chunk_end;
      logic [16:0] hole_end;
      logic [15:0] cs;
      logic [15:0] cl;
      r = '0;
      r.status = ST_OK;
      if (rq.op == OP_ALLOC) begin
         pick = -1;
         if (rq.request_size == 0) begin
            r.status = ST_BAD_SIZE;
         end else begin
            for (int k = 0; k < hole_count; k++) begin
               if (hole_size[k] >= rq.request_size) begin
                  case (cfg_placement)
                     PL_FIRST: if (pick < 0) pick = k;
                     PL_BEST: if (pick < 0 || hole_size[k] < hole_size[pick]) pick = k;
                     PL_WORST: if (pick < 0 || hole_size[k] > hole_size[pick]) pick = k;
                     default: ;
                  endcase
               end
            end
            if (pick < 0) begin
               r.status = ST_NO_FIT;
            end else if (chunk_count >= CHUNKS) begin
               r.status = ST_FULL;
            end else begin
               for (int k = chunk_count; k > 0; k--) begin
                  chunk_tag[k] = chunk_tag[k - 1];
                  chunk_base[k] = chunk_base[k - 1];
                  chunk_size[k] = chunk_size[k - 1];
               end
               chunk_tag[0] = rq.chunk_name;
               chunk_base[0] = hole_base[pick];
               chunk_size[0] = rq.request_size;
               chunk_count++;
               r.start_addr = hole_base[pick];
               hole_base[pick] = hole_base[pick] + rq.request_size;
               hole_size[pick] = hole_size[pick] - rq.request_size;
               if (hole_size[pick] == 0) remove_hole(pick);
               units_in_use = units_in_use + rq.request_size;
            end
         end
      end else if (rq.op == OP_FREE) begin
         found = -1;
         upper = -1;
         lower = -1;
         for (int k = 0; k < chunk_count; k++) begin
            if (found < 0 && chunk_tag[k] == rq.chunk_name) found = k;
         end
         if (found < 0) begin
            r.status = ST_NOT_FOUND;
         end else begin
            cs = chunk_base[found];
            cl = chunk_size[found];
            chunk_end = {1'b0, cs} + cl;
            // Adjacency uses unwrapped sums, so a range ending at the top of
            // the address space never touches a hole at address zero.
            for (int k = 0; k < hole_count; k++) begin
               hole_end = {1'b0, hole_base[k]} + hole_size[k];
               if (cs < hole_base[k] && chunk_end == {1'b0, hole_base[k]}) upper = k;
               if (cs > hole_base[k] && hole_end == {1'b0, cs}) lower = k;
            end
            if (upper < 0 && lower < 0 && hole_count >= HOLES) begin
               r.status = ST_FULL;
            end else begin
               for (int k = found; k + 1 < chunk_count; k++) begin
                  chunk_tag[k] = chunk_tag[k + 1];
                  chunk_base[k] = chunk_base[k + 1];
                  chunk_size[k] = chunk_size[k + 1];
               end
               chunk_count--;
               chunk_tag[chunk_count] = '0;
               chunk_base[chunk_count] = '0;
               chunk_size[chunk_count] = '0;
               if (upper >= 0 && lower >= 0) begin
                  hole_size[lower] = hole_size[lower] + cl + hole_size[upper];
                  remove_hole(upper);
               end else if (upper >= 0) begin
                  hole_base[upper] = cs;
                  hole_size[upper] = hole_size[upper] + cl;
               end else if (lower >= 0) begin
                  hole_size[lower] = hole_size[lower] + cl;
               end else begin
                  for (int k = hole_count; k > 0; k--) begin
                     hole_base[k] = hole_base[k - 1];
                     hole_size[k] = hole_size[k - 1];
                  end
                  hole_base[0] = cs;
                  hole_size[0] = cl;
                  hole_count++;
               end
               units_in_use = units_in_use - cl;
            end
         end
      end else if (rq.op == OP_CLEAR) begin
         wipe_tables();
      end
      r.used_total = units_in_use;
      return r;
   endfunction

   // Sends one word, holding it until the handshake completes. Valid stays
   // high after an accept until the next word or an idle gap replaces it.
   task automatic send_word(logic [1:0] op, logic [7:0] name, logic [15:0] size);
      req_type rq;
      rq.op = op;
      rq.chunk_name = name;
      rq.request_size = size;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_words.push_back(allocator_result(rq));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // Register writes happen only with the block idle.
   task automatic write_csr(logic idx, logic [15:0] value);
      drain();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_CAPACITY) cfg_capacity = value;
      else cfg_placement = placement_type'(value[1:0]);
   endtask

   // Receiver side: random stalls, one nonblocking drive per edge.
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            $error("unexpected result word %h", rsp_data);
            mismatches++;
         end else begin
            want = expected_words.pop_front();
            if (rsp_data.start_addr !== want.start_addr) begin
               $error("start_addr expected %0d actual %0d", want.start_addr,
                      rsp_data.start_addr);
               mismatches++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_data.status);
               mismatches++;
            end
            if (rsp_data.used_total !== want.used_total) begin
               $error("used_total expected %0d actual %0d", want.used_total,
                      rsp_data.used_total);
               mismatches++;
            end
         end
      end
   end

   // Watchdog on cycles in which no word moves on either channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic set_idling(int phase);
      case (phase % 4)
         0: begin send_idle_pct = 0; recv_stall_pct = 0; end
         1: begin send_idle_pct = 57; recv_stall_pct = 0; end
         2: begin send_idle_pct = 0; recv_stall_pct = 57; end
         default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
   endtask

   // Directed: bad size, exact fit, merges, missing names and clears.
   task automatic test_directed();
      send_word(OP_ALLOC, 8'h00, 16'd0);
      send_word(OP_ALLOC, 8'h01, 16'd10);
      send_word(OP_ALLOC, 8'h02, 16'd20);
      send_word(OP_ALLOC, 8'h03, 16'd10);
      send_word(OP_FREE, 8'h01, 16'hFFFF);
      send_word(OP_FREE, 8'h03, 16'd0);
      send_word(OP_ALLOC, 8'hFF, 16'd10);
      send_word(OP_FREE, 8'h02, 16'd0);
      send_word(OP_FREE, 8'hFF, 16'd0);
      send_word(OP_FREE, 8'h55, 16'd0);
      send_word(OP_ALLOC, 8'hAA, 16'd101);
      send_word(OP_ALLOC, 8'hAA, 16'd100);
      send_word(OP_FREE, 8'hAA, 16'd0);
      send_word(OP_SPARE, 8'h12, 16'd7);
      send_word(OP_CLEAR, 8'hFF, 16'hFFFF);
   endtask

   // Fills the chunk table, then fragments the holes and merges them back.
   task automatic test_tables_full();
      write_csr(CSR_CAPACITY, 16'd40);
      send_word(OP_CLEAR, 8'h00, 16'd0);
      for (int k = 0; k < 17; k++) send_word(OP_ALLOC, k[7:0], 16'd2);
      for (int k = 0; k < 16; k += 2) send_word(OP_FREE, k[7:0], 16'd0);
      send_word(OP_FREE, 8'd15, 16'd0);
      send_word(OP_FREE, 8'd1, 16'd0);
      send_word(OP_ALLOC, 8'h20, 16'd40);
   endtask

   // Random mix of allocates, frees, clears and spare words under random placements and every idling mode.
   task automatic test_random(int count);
      int op_pick;
      logic [15:0] size;
      logic [15:0] cap;
      for (int phase = 0; phase < 12; phase++) begin
         case (phase % 6)
            0: cap = 16'hFFFF;
            1: cap = 16'd1;
            2: cap = 16'd0;
            default: cap = 16'($urandom_range(20, 400));
         endcase
         write_csr(CSR_CAPACITY, cap);
         write_csr(CSR_PLACEMENT, 16'($urandom_range(3)));
         set_idling(phase);
         send_word(OP_CLEAR, 8'($urandom), 16'($urandom));
         for (int k = 0; k < count / 12; k++) begin
            op_pick = $urandom_range(99);
            if ($urandom_range(7) == 0) size = 16'($urandom);
            else if (cap > 16) size = 16'($urandom_range(0, cap / 6));
            else size = 16'($urandom_range(0, 3));
            if (op_pick < 50) send_word(OP_ALLOC, 8'($urandom_range(15)), size);
            else if (op_pick < 93) send_word(OP_FREE, 8'($urandom_range(15)), size);
            else if (op_pick < 96) send_word(OP_FREE, 8'($urandom), size);
            else if (op_pick < 98) send_word(OP_CLEAR, 8'($urandom), size);
            else send_word(OP_SPARE, 8'($urandom), size);
         end
      end
   endtask

   initial begin
      cfg_capacity = 16'd100;
      cfg_placement = PL_FIRST;
      wipe_tables();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      write_csr(CSR_PLACEMENT, 16'(PL_BEST));
      test_directed();
      write_csr(CSR_PLACEMENT, 16'(PL_WORST));
      test_directed();
      test_tables_full();
      test_random(1560);
      drain();
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
